// ----- rtl/core/rdss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdss_pkg
// Shared types and fixed widths of the reaction-diffusion stencil step unit.
// ----------------------------------------------------------------------------
package rdss_pkg;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;
  localparam int NB_W      = VAL_W + 1;
  localparam int LAP_W     = VAL_W + 4;
  localparam int PROD_W    = GAIN_W + 1 + LAP_W;
  localparam int DECAY_W   = GAIN_W + 1 + VAL_W;
  localparam int ACC_W     = PROD_W + 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_COMMIT = 2'd3
  } op_t;

  localparam logic [MODE_W-1:0] BND_NEUMANN   = 2'd0;
  localparam logic [MODE_W-1:0] BND_DIRICHLET = 2'd1;
  localparam logic [MODE_W-1:0] BND_PERIODIC  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCTION    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_TOP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_BOTTOM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEFT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_RIGHT    = 3'd7;

endpackage

// ----- rtl/core/reaction_diffusion_stencil_step_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reaction_diffusion_stencil_step_unit
// Two-bank Q16.16 grid with a five-point diffusion, production and decay step.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid / in_stall) carry an operation, a cell address and a
//   write value. Write stores into the current bank, read returns the stored
//   cell, update computes one cell from the current bank and stores it in the
//   other bank, commit swaps the banks. Read and update return one output word
//   (out_valid / out_stall); write and commit return none.
//   Both banks sit in one single-port memory, one access per cycle. A read
//   captures the memory word and then loads it into the output register. An
//   update makes five memory reads (centre and four neighbours), accumulates
//   the last neighbour, multiplies by the diffusion gain and then by the decay
//   gain, rounds and writes the result, and loads the output register.
//   Reads and updates outside the grid return a zero word with no memory read.
//   in_stall is high while an item is in flight; the next item is taken once
//   its result sits in the output register. A stalled output word holds, and
//   a new result waits in the unit until the register frees up.
//   Reset clears the output valid flag, selects bank a, sets periodic boundary
//   and zeroes all gains and offsets. Grid contents are undefined until
//   written. Configuration is written through cfg_we / cfg_index / cfg_wdata.
// ----------------------------------------------------------------------------
module reaction_diffusion_stencil_step_unit
  import rdss_pkg::*;
#(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [IDX_W-1:0]     in_row_index,
  input  logic [IDX_W-1:0]     in_col_index,
  input  logic signed [VAL_W-1:0] in_write_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [VAL_W-1:0] out_cell_value,
  output logic                 out_saturated
);

  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int CELL_W = $clog2(CELLS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_READ_CAP, S_FETCH_N, S_FETCH_S, S_FETCH_W, S_FETCH_E,
    S_ADD_E, S_MUL_LAP, S_MUL_DECAY, S_ROUND, S_EMIT
  } state_t;

  typedef enum logic [1:0] {DIR_N, DIR_S, DIR_W, DIR_E} dir_t;

  function automatic logic [CELL_W-1:0] cell_of(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return CELL_W'(int'(r) * GRID_COLS + int'(c));
  endfunction

  state_t state_r;
  logic   cur_bank_r;

  logic [MODE_W-1:0]       boundary_mode_r;
  logic [GAIN_W-1:0]       diffusion_gain_r;
  logic [GAIN_W-1:0]       decay_gain_r;
  logic signed [VAL_W-1:0] production_step_r;
  logic signed [VAL_W-1:0] edge_top_r;
  logic signed [VAL_W-1:0] edge_bottom_r;
  logic signed [VAL_W-1:0] edge_left_r;
  logic signed [VAL_W-1:0] edge_right_r;

  logic [ROW_W-1:0]          row_r;
  logic [COL_W-1:0]          col_r;
  logic signed [VAL_W-1:0]   old_r;
  logic signed [LAP_W-1:0]   lap_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [DECAY_W-1:0] decay_r;
  logic signed [ACC_W-1:0]   base_r;
  logic [VAL_W-1:0]          res_val_r;
  logic                      res_sat_r;

  logic                      out_valid_r;
  logic [VAL_W-1:0]          out_val_r;
  logic                      out_sat_r;

  logic [VAL_W-1:0] grid_mem [2][CELLS];
  logic [VAL_W-1:0] rd_data_r;

  logic             mem_we, mem_re, mem_bank;
  logic [CELL_W-1:0] mem_cell;
  logic [VAL_W-1:0] mem_wdata;

  logic             in_acc, in_inside, periodic;
  logic [ROW_W-1:0] in_row_cut;
  logic [COL_W-1:0] in_col_cut;
  dir_t             issue_dir, acc_dir;
  logic [ROW_W-1:0] nb_row;
  logic [COL_W-1:0] nb_col;
  logic             acc_ghost;
  logic signed [VAL_W-1:0] acc_off;
  logic signed [NB_W-1:0]  nb_cell, nb_off, nb_val;
  logic signed [ACC_W-1:0] acc_rnd, shifted;
  logic             sat_hi, sat_lo;
  logic [VAL_W-1:0] res_val;

  assign in_stall       = (state_r != S_IDLE);
  assign in_acc         = in_valid && !in_stall;
  assign in_inside      = (int'(in_row_index) < GRID_ROWS) && (int'(in_col_index) < GRID_COLS);
  assign in_row_cut     = ROW_W'(in_row_index);
  assign in_col_cut     = COL_W'(in_col_index);
  assign periodic       = (boundary_mode_r != BND_NEUMANN) && (boundary_mode_r != BND_DIRICHLET);
  assign out_valid      = out_valid_r;
  assign out_cell_value = out_val_r;
  assign out_saturated  = out_sat_r;

  always_comb begin
    issue_dir = DIR_N;
    acc_dir   = DIR_N;
    unique case (state_r)
      S_FETCH_S: begin
        issue_dir = DIR_S;
        acc_dir   = DIR_N;
      end
      S_FETCH_W: begin
        issue_dir = DIR_W;
        acc_dir   = DIR_S;
      end
      S_FETCH_E: begin
        issue_dir = DIR_E;
        acc_dir   = DIR_W;
      end
      S_ADD_E: begin
        acc_dir   = DIR_E;
      end
      default: begin
        issue_dir = DIR_N;
        acc_dir   = DIR_N;
      end
    endcase
  end

  always_comb begin
    nb_row = row_r;
    nb_col = col_r;
    unique case (issue_dir)
      DIR_N: nb_row = (row_r == '0) ? (periodic ? ROW_LAST : row_r) : row_r - 1'b1;
      DIR_S: nb_row = (row_r == ROW_LAST) ? (periodic ? '0 : row_r) : row_r + 1'b1;
      DIR_W: nb_col = (col_r == '0) ? (periodic ? COL_LAST : col_r) : col_r - 1'b1;
      DIR_E: nb_col = (col_r == COL_LAST) ? (periodic ? '0 : col_r) : col_r + 1'b1;
    endcase
  end

  always_comb begin
    unique case (acc_dir)
      DIR_N: begin
        acc_ghost = (row_r == '0);
        acc_off   = edge_top_r;
      end
      DIR_S: begin
        acc_ghost = (row_r == ROW_LAST);
        acc_off   = edge_bottom_r;
      end
      DIR_W: begin
        acc_ghost = (col_r == '0);
        acc_off   = edge_left_r;
      end
      DIR_E: begin
        acc_ghost = (col_r == COL_LAST);
        acc_off   = edge_right_r;
      end
    endcase
    nb_cell = {rd_data_r[VAL_W-1], rd_data_r};
    nb_off  = {acc_off[VAL_W-1], acc_off};
    priority if (acc_ghost && boundary_mode_r == BND_NEUMANN) begin
      nb_val = nb_cell - nb_off;
    end else if (acc_ghost && boundary_mode_r == BND_DIRICHLET) begin
      nb_val = nb_off - nb_cell;
    end else begin
      nb_val = nb_cell;
    end
  end

  always_comb begin
    acc_rnd = base_r - {{(ACC_W-DECAY_W){decay_r[DECAY_W-1]}}, decay_r}
            + ACC_W'(1 << (FRAC_W - 1));
    shifted = acc_rnd >>> FRAC_W;
    sat_hi  = !shifted[ACC_W-1] && (|shifted[ACC_W-2:VAL_W-1]);
    sat_lo  = shifted[ACC_W-1] && !(&shifted[ACC_W-2:VAL_W-1]);
    priority if (sat_hi) begin
      res_val = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (sat_lo) begin
      res_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res_val = shifted[VAL_W-1:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_bank  = cur_bank_r;
    mem_cell  = cell_of(in_row_cut, in_col_cut);
    mem_wdata = in_write_value;
    unique case (state_r)
      S_IDLE: begin
        if (rst_n && in_acc && in_inside) begin
          mem_we = (in_operation == OP_WRITE);
          mem_re = (in_operation == OP_READ) || (in_operation == OP_UPDATE);
        end
      end
      S_FETCH_N, S_FETCH_S, S_FETCH_W, S_FETCH_E: begin
        mem_re   = 1'b1;
        mem_cell = cell_of(nb_row, nb_col);
      end
      S_ROUND: begin
        mem_we    = rst_n;
        mem_bank  = ~cur_bank_r;
        mem_cell  = cell_of(row_r, col_r);
        mem_wdata = res_val;
      end
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_bank][mem_cell] <= mem_wdata;
    end else if (mem_re) begin
      rd_data_r <= grid_mem[mem_bank][mem_cell];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      cur_bank_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      boundary_mode_r   <= BND_PERIODIC;
      diffusion_gain_r  <= '0;
      decay_gain_r      <= '0;
      production_step_r <= '0;
      edge_top_r        <= '0;
      edge_bottom_r     <= '0;
      edge_left_r       <= '0;
      edge_right_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BOUNDARY_MODE: boundary_mode_r   <= cfg_wdata[MODE_W-1:0];
          REG_DIFFUSION:     diffusion_gain_r  <= cfg_wdata[GAIN_W-1:0];
          REG_DECAY:         decay_gain_r      <= cfg_wdata[GAIN_W-1:0];
          REG_PRODUCTION:    production_step_r <= cfg_wdata;
          REG_EDGE_TOP:      edge_top_r        <= cfg_wdata;
          REG_EDGE_BOTTOM:   edge_bottom_r     <= cfg_wdata;
          REG_EDGE_LEFT:     edge_left_r       <= cfg_wdata;
          REG_EDGE_RIGHT:    edge_right_r      <= cfg_wdata;
        endcase
      end

      if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            row_r <= in_row_cut;
            col_r <= in_col_cut;
            unique case (in_operation)
              OP_WRITE: begin
              end
              OP_COMMIT: begin
                cur_bank_r <= ~cur_bank_r;
              end
              OP_READ, OP_UPDATE: begin
                if (!in_inside) begin
                  res_val_r <= '0;
                  res_sat_r <= 1'b0;
                  state_r   <= S_EMIT;
                end else if (in_operation == OP_READ) begin
                  state_r <= S_READ_CAP;
                end else begin
                  state_r <= S_FETCH_N;
                end
              end
            endcase
          end
        end
        S_READ_CAP: begin
          res_val_r <= rd_data_r;
          res_sat_r <= 1'b0;
          state_r   <= S_EMIT;
        end
        S_FETCH_N: begin
          old_r   <= rd_data_r;
          lap_r   <= '0 - ({{(LAP_W-VAL_W){rd_data_r[VAL_W-1]}}, rd_data_r} << 2);
          state_r <= S_FETCH_S;
        end
        S_FETCH_S: begin
          lap_r   <= lap_r + {{(LAP_W-NB_W){nb_val[NB_W-1]}}, nb_val};
          state_r <= S_FETCH_W;
        end
        S_FETCH_W: begin
          lap_r   <= lap_r + {{(LAP_W-NB_W){nb_val[NB_W-1]}}, nb_val};
          state_r <= S_FETCH_E;
        end
        S_FETCH_E: begin
          lap_r   <= lap_r + {{(LAP_W-NB_W){nb_val[NB_W-1]}}, nb_val};
          state_r <= S_ADD_E;
        end
        S_ADD_E: begin
          lap_r   <= lap_r + {{(LAP_W-NB_W){nb_val[NB_W-1]}}, nb_val};
          state_r <= S_MUL_LAP;
        end
        S_MUL_LAP: begin
          prod_r  <= $signed({1'b0, diffusion_gain_r}) * lap_r;
          state_r <= S_MUL_DECAY;
        end
        S_MUL_DECAY: begin
          decay_r <= $signed({1'b0, decay_gain_r}) * old_r;
          base_r  <= {{(ACC_W-VAL_W-FRAC_W){old_r[VAL_W-1]}}, old_r, {FRAC_W{1'b0}}}
                   + {{(ACC_W-VAL_W-FRAC_W){production_step_r[VAL_W-1]}},
                      production_step_r, {FRAC_W{1'b0}}}
                   + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          res_val_r <= res_val;
          res_sat_r <= sat_hi || sat_lo;
          state_r   <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_val_r   <= res_val_r;
            out_sat_r   <= res_sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/rdss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdss_checker
// Port-level checks of the reaction-diffusion stencil step unit.
// ----------------------------------------------------------------------------
module rdss_checker
  import rdss_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [OP_W-1:0]      in_operation,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [VAL_W-1:0]     out_cell_value,
  input logic                 out_saturated
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_value) && $stable(out_saturated))
    else $error("stalled output word changed");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_cell_value == 32'h7fffffff) || (out_cell_value == 32'h80000000))
    else $error("saturated word not at a range limit");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid &&
      (in_operation == OP_WRITE || in_operation == OP_COMMIT) |=> !out_valid)
    else $error("write or commit produced an output word");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == OP_READ || in_operation == OP_UPDATE)
      |=> in_stall)
    else $error("read or update did not hold off the next word");

endmodule

bind reaction_diffusion_stencil_step_unit rdss_checker u_rdss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_operation   (in_operation),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_cell_value (out_cell_value),
  .out_saturated  (out_saturated)
);
